### sv/upsq_pkg.sv
package upsq_pkg;

  // Field widths
  localparam int unsigned MV_W    = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned EVENT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Protection state codes
  localparam logic [STATE_W-1:0] ST_NORMAL    = 3'd0;
  localparam logic [STATE_W-1:0] ST_LOW       = 3'd1;
  localparam logic [STATE_W-1:0] ST_SHUTDOWN  = 3'd2;
  localparam logic [STATE_W-1:0] ST_PROTECTED = 3'd3;
  localparam logic [STATE_W-1:0] ST_RECOVERY  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUT_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REC_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_EN    = 3'd6;

  // Register reset values
  localparam logic [MV_W-1:0]   RST_LOW_THR    = 16'd18000;
  localparam logic [MV_W-1:0]   RST_REC_THR    = 16'd20000;
  localparam logic [TICK_W-1:0] RST_SHUT_DELAY = 16'd60;
  localparam logic [TICK_W-1:0] RST_REC_HOLD   = 16'd5;
  localparam logic [TICK_W-1:0] RST_FAN_DELAY  = 16'd60;

  // Voltage constants in millivolts
  localparam logic [MV_W-1:0] VALID_FLOOR_MV = 16'd5000;
  localparam logic [MV_W-1:0] TEST_OFFSET_MV = 16'd500;

  typedef struct packed {
    logic [MV_W-1:0]   low_thr;
    logic [MV_W-1:0]   rec_thr;
    logic [TICK_W-1:0] shut_delay;
    logic [TICK_W-1:0] rec_hold;
    logic [TICK_W-1:0] fan_delay;
    logic              alert_en;
    logic              clear_en;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0] sample_mv;
    logic            sample_ok;
    logic            test_request;
    logic            main_powered;
    logic            aux_powered;
    logic            aux_online;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0] prot_state;
    logic [TICK_W-1:0]  countdown_left;
    logic [TICK_W-1:0]  recovery_left;
    logic [EVENT_W-1:0] event_count;
    logic               hold_main_reset;
    logic               toggle_aux_power;
    logic               clear_display;
    logic               stop_fans;
    logic               restart_request;
    logic               alert_led;
  } result_t;

endpackage

### sv/upsq_in_if.sv
interface upsq_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_mv;
  logic        sample_ok;
  logic        test_request;
  logic        main_powered;
  logic        aux_powered;
  logic        aux_online;

  modport source (
    output valid, sample_mv, sample_ok, test_request, main_powered, aux_powered, aux_online,
    input  ready
  );
  modport sink (
    input  valid, sample_mv, sample_ok, test_request, main_powered, aux_powered, aux_online,
    output ready
  );
endinterface

### sv/upsq_out_if.sv
interface upsq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  prot_state;
  logic [15:0] countdown_left;
  logic [15:0] recovery_left;
  logic [31:0] event_count;
  logic        hold_main_reset;
  logic        toggle_aux_power;
  logic        clear_display;
  logic        stop_fans;
  logic        restart_request;
  logic        alert_led;

  modport source (
    output valid, prot_state, countdown_left, recovery_left, event_count, hold_main_reset,
           toggle_aux_power, clear_display, stop_fans, restart_request, alert_led,
    input  ready
  );
  modport sink (
    input  valid, prot_state, countdown_left, recovery_left, event_count, hold_main_reset,
           toggle_aux_power, clear_display, stop_fans, restart_request, alert_led,
    output ready
  );
endinterface

### sv/upsq_cfg_regs.sv
module upsq_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [upsq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [upsq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output upsq_pkg::cfg_t                      cfg_o
);
  import upsq_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_THR:    cfg_d.low_thr    = cfg_wdata_i;
        CFG_REC_THR:    cfg_d.rec_thr    = cfg_wdata_i;
        CFG_SHUT_DELAY: cfg_d.shut_delay = cfg_wdata_i;
        CFG_REC_HOLD:   cfg_d.rec_hold   = cfg_wdata_i;
        CFG_FAN_DELAY:  cfg_d.fan_delay  = cfg_wdata_i;
        CFG_ALERT_EN:   cfg_d.alert_en   = cfg_wdata_i[0];
        CFG_CLEAR_EN:   cfg_d.clear_en   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr    <= RST_LOW_THR;
      cfg_q.rec_thr    <= RST_REC_THR;
      cfg_q.shut_delay <= RST_SHUT_DELAY;
      cfg_q.rec_hold   <= RST_REC_HOLD;
      cfg_q.fan_delay  <= RST_FAN_DELAY;
      cfg_q.alert_en   <= 1'b1;
      cfg_q.clear_en   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/upsq_core.sv
module upsq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  upsq_pkg::item_t   item_i,
  input  upsq_pkg::cfg_t    cfg_i,
  output upsq_pkg::result_t res_o
);
  import upsq_pkg::*;

  // Signed working width: 16-bit millivolts plus headroom for the test offset
  localparam int unsigned VW = MV_W + 2;

  logic [STATE_W-1:0] mode_q, mode_d, mode_e;
  logic [TICK_W-1:0]  cd_q, cd_d, cd_e;
  logic [TICK_W-1:0]  rt_q, rt_d, rt_e;
  logic [TICK_W-1:0]  ft_q, ft_d;
  logic               fo_q, fo_d;
  logic [EVENT_W-1:0] ev_q, ev_d;
  logic               test_q, test_d;

  logic signed [VW-1:0] volt;
  logic signed [VW-1:0] lo_s;
  logic signed [VW-1:0] rc_s;
  logic                 use_v;

  // Voltage selection: latched test mode overrides the sample
  always_comb begin
    test_d = test_q | item_i.test_request;
    lo_s   = $signed({2'b00, cfg_i.low_thr});
    rc_s   = $signed({2'b00, cfg_i.rec_thr});
    volt   = test_d ? (lo_s - $signed({2'b00, TEST_OFFSET_MV}))
                    : $signed({2'b00, item_i.sample_mv});
    use_v  = test_d | (item_i.sample_ok & (item_i.sample_mv > VALID_FLOOR_MV));
  end

  // Threshold evaluation
  always_comb begin
    mode_e = mode_q;
    cd_e   = cd_q;
    rt_e   = rt_q;
    ev_d   = ev_q;
    if (use_v) begin
      case (mode_q)
        ST_NORMAL: begin
          if (volt < lo_s) begin
            mode_e = ST_LOW;
            cd_e   = cfg_i.shut_delay;
            if (ev_q != '1) ev_d = ev_q + EVENT_W'(1);
          end
        end
        ST_LOW: begin
          if (volt >= rc_s) begin
            mode_e = ST_NORMAL;
            cd_e   = '0;
          end
        end
        ST_PROTECTED: begin
          if (volt >= rc_s) begin
            mode_e = ST_RECOVERY;
            rt_e   = cfg_i.rec_hold;
          end
        end
        ST_RECOVERY: begin
          if (volt < rc_s) begin
            rt_e = '0;
            if (volt < lo_s) begin
              mode_e = ST_LOW;
              cd_e   = cfg_i.shut_delay;
            end else begin
              mode_e = ST_NORMAL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Timers, shutdown actions and pulses
  always_comb begin
    mode_d = mode_e;
    cd_d   = cd_e;
    rt_d   = rt_e;
    ft_d   = ft_q;
    fo_d   = fo_q;
    res_o.hold_main_reset  = 1'b0;
    res_o.toggle_aux_power = 1'b0;
    res_o.clear_display    = 1'b0;
    res_o.stop_fans        = 1'b0;
    res_o.restart_request  = 1'b0;
    case (mode_e)
      ST_LOW: begin
        if (cd_e != '0) begin
          cd_d = cd_e - TICK_W'(1);
          if (cd_e == TICK_W'(1)) mode_d = ST_SHUTDOWN;
        end
      end
      ST_RECOVERY: begin
        if (rt_e != '0) begin
          rt_d = rt_e - TICK_W'(1);
          if (rt_e == TICK_W'(1)) begin
            res_o.restart_request = 1'b1;
            mode_d = ST_NORMAL;
          end
        end
      end
      ST_SHUTDOWN: begin
        res_o.hold_main_reset  = item_i.main_powered;
        res_o.toggle_aux_power = item_i.aux_powered & item_i.aux_online;
        res_o.clear_display    = cfg_i.clear_en;
        ft_d   = cfg_i.fan_delay;
        fo_d   = 1'b0;
        mode_d = ST_PROTECTED;
      end
      ST_PROTECTED: begin
        if (!fo_q && ft_q != '0) begin
          ft_d = ft_q - TICK_W'(1);
          if (ft_q == TICK_W'(1)) begin
            res_o.stop_fans = 1'b1;
            fo_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_o.prot_state     = mode_d;
    res_o.countdown_left = cd_d;
    res_o.recovery_left  = rt_d;
    res_o.event_count    = ev_d;
    res_o.alert_led      = cfg_i.alert_en &
                           ((mode_d == ST_LOW) | (mode_d == ST_SHUTDOWN) |
                            (mode_d == ST_PROTECTED));
  end

  // State registers advance once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ST_NORMAL;
      cd_q   <= '0;
      rt_q   <= '0;
      ft_q   <= '0;
      fo_q   <= 1'b0;
      ev_q   <= '0;
      test_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cd_q   <= cd_d;
      rt_q   <= rt_d;
      ft_q   <= ft_d;
      fo_q   <= fo_d;
      ev_q   <= ev_d;
      test_q <= test_d;
    end
  end

`ifndef SYNTHESIS
  // Shutdown lasts exactly one request
  a_shutdown_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_q == ST_SHUTDOWN |=> mode_q == ST_PROTECTED)
    else $error("shutdown did not move to protected");

  // Shutdown commands only come out of the shutdown state
  a_shutdown_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.hold_main_reset || res_o.toggle_aux_power || res_o.clear_display)
    |-> mode_q == ST_SHUTDOWN)
    else $error("shutdown command outside shutdown");

  // Fans stop only from protected
  a_fans_prot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.stop_fans |-> mode_q == ST_PROTECTED && !fo_q)
    else $error("fan stop outside protected");

  // Restart only after the last hold tick
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.restart_request |=> mode_q == ST_NORMAL && rt_q == '0)
    else $error("restart request with bad state");

  // Event count never goes down
  a_events_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> ev_q >= $past(ev_q))
    else $error("event count decreased");
`endif

endmodule

### sv/undervoltage_protection_sequencer.sv
// Path: an accepted request passes through two registers (input stage, result
//   stage) before it appears on the result channel.
// Throughput: one request per cycle unless the result channel stalls; the
//   single-pass step logic between input and result registers sets this rate.
// Reset: rst_ni is asynchronous, active low; state, timers and event count
//   clear, registers return to their defaults, both channels empty.
module undervoltage_protection_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  upsq_in_if.sink                         in_i,
  upsq_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [upsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [upsq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import upsq_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    in_valid_q, out_valid_q;
  logic    advance, in_take;

  upsq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: step when an input is held and the result slot is free or being drained
  assign advance  = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | advance;
  assign in_take  = in_i.valid & in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.sample_mv    <= in_i.sample_mv;
      item_q.sample_ok    <= in_i.sample_ok;
      item_q.test_request <= in_i.test_request;
      item_q.main_powered <= in_i.main_powered;
      item_q.aux_powered  <= in_i.aux_powered;
      item_q.aux_online   <= in_i.aux_online;
    end
  end

  upsq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.prot_state       = res_q.prot_state;
  assign out_o.countdown_left   = res_q.countdown_left;
  assign out_o.recovery_left    = res_q.recovery_left;
  assign out_o.event_count      = res_q.event_count;
  assign out_o.hold_main_reset  = res_q.hold_main_reset;
  assign out_o.toggle_aux_power = res_q.toggle_aux_power;
  assign out_o.clear_display    = res_q.clear_display;
  assign out_o.stop_fans        = res_q.stop_fans;
  assign out_o.restart_request  = res_q.restart_request;
  assign out_o.alert_led        = res_q.alert_led;

endmodule
